[hw/rtl/spk_pkg.sv]
`timescale 1ns / 1ps

package spk_pkg;

  // depth of the ranked peak list, one cell per entry
  localparam int unsigned Peaks = 10;

  localparam int unsigned MassW  = 24;
  localparam int unsigned AbunW  = 32;
  localparam int unsigned RankW  = 6;
  localparam int unsigned RptW   = 7;
  localparam int unsigned DrainW = $clog2(Peaks + 1);

  localparam logic [RptW-1:0] RptReset  = RptW'(10);
  localparam logic [RptW-1:0] MaxReport = RptW'(64);

  typedef struct packed {
    logic [MassW-1:0] mass;
    logic [AbunW-1:0] abundance;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[hw/rtl/spk_stream_if.sv]
`timescale 1ns / 1ps

interface spk_smp_if;
  logic                     valid;
  logic                     ready;
  logic [spk_pkg::MassW-1:0] mass;
  logic [spk_pkg::AbunW-1:0] abundance;
  logic                     last_sample;

  modport source (output valid, output mass, output abundance, output last_sample,
                  input ready);
  modport sink (input valid, input mass, input abundance, input last_sample,
                output ready);
endinterface

interface spk_peak_if;
  logic                     valid;
  logic                     ready;
  logic [spk_pkg::RankW-1:0] peak_rank;
  logic [spk_pkg::MassW-1:0] peak_mass;
  logic [spk_pkg::AbunW-1:0] peak_abundance;
  logic                     last_peak;

  modport source (output valid, output peak_rank, output peak_mass,
                  output peak_abundance, output last_peak, input ready);
  modport sink (input valid, input peak_rank, input peak_mass,
                input peak_abundance, input last_peak, output ready);
endinterface

[hw/rtl/spectrum_top_k_peak_finder_core.sv]
`timescale 1ns / 1ps
// throughput: one sample per cycle while a spectrum streams in
// after the last sample transfer the insertion chain drains in ST_DRAIN, one cell per cycle,
//   and the first result then leaves ST_EMIT through the output register
// report run: max(1, min(rpt_q, 64)) results, one per cycle unless stalled, then sampling resumes
// reset: asynchronous, clears the peak list, detector state and report count (back to 10)

module spectrum_top_k_peak_finder_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [spk_pkg::RptW-1:0] cfg_wdata_i,
  spk_smp_if.sink                  smp_i,
  spk_peak_if.source               pk_o
);

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_DRAIN = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [spk_pkg::RptW-1:0]   rpt_q;
  logic [spk_pkg::RptW-1:0]   rpt_n;
  logic [spk_pkg::DrainW-1:0] drain_q, drain_d;
  logic [spk_pkg::RankW-1:0]  rank_q, rank_d;

  logic                       have_prev_q, have_prev_d;
  logic                       taken_q, taken_d;
  spk_pkg::entry_t            prev_q, prev_d;

  logic                       out_valid_q, out_valid_d;
  logic [spk_pkg::RankW-1:0]  out_rank_q, out_rank_d;
  spk_pkg::entry_t            out_ent_q, out_ent_d;
  logic                       out_last_q, out_last_d;

  logic                       smp_xfer;
  logic                       emit_go;
  logic                       emit_last;
  spk_pkg::entry_t            ins;
  spk_pkg::cell_ctrl_t        ctrl;

  spk_pkg::entry_t            entry_w [spk_pkg::Peaks];
  spk_pkg::entry_t            carry_w [spk_pkg::Peaks];
  logic                       bump_w  [spk_pkg::Peaks];

  assign smp_i.ready = (state_q == ST_RUN);
  assign smp_xfer    = smp_i.valid && smp_i.ready;

  // report count: zero reads as one, large values saturate
  always_comb begin
    rpt_n = rpt_q;
    if (rpt_q == '0) begin
      rpt_n = spk_pkg::RptW'(1);
    end else if (rpt_q > spk_pkg::MaxReport) begin
      rpt_n = spk_pkg::MaxReport;
    end
  end

  // peak detection against the previous sample
  always_comb begin
    have_prev_d = have_prev_q;
    taken_d     = taken_q;
    prev_d      = prev_q;
    ins         = '0;
    if (smp_xfer) begin
      if (have_prev_q) begin
        if (prev_q.abundance < smp_i.abundance) begin
          taken_d = 1'b0;
        end else if (prev_q.abundance > smp_i.abundance && !taken_q) begin
          ins     = prev_q;
          taken_d = 1'b1;
        end
      end
      prev_d.mass      = smp_i.mass;
      prev_d.abundance = smp_i.abundance;
      have_prev_d      = 1'b1;
      if (smp_i.last_sample) begin
        have_prev_d = 1'b0;
        taken_d     = 1'b0;
        prev_d      = '0;
      end
    end
  end

  assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || pk_o.ready);
  assign emit_last = (rank_q == spk_pkg::RankW'(rpt_n - spk_pkg::RptW'(1)));

  always_comb begin
    state_d     = state_q;
    drain_d     = drain_q;
    rank_d      = rank_q;
    ctrl        = '0;
    out_valid_d = out_valid_q;
    out_rank_d  = out_rank_q;
    out_ent_d   = out_ent_q;
    out_last_d  = out_last_q;
    if (out_valid_q && pk_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_RUN: begin
        if (smp_xfer && smp_i.last_sample) begin
          state_d = ST_DRAIN;
          drain_d = '0;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + spk_pkg::DrainW'(1);
        if (drain_q == spk_pkg::DrainW'(spk_pkg::Peaks - 1)) begin
          state_d = ST_EMIT;
          rank_d  = '0;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_rank_d  = rank_q;
          out_ent_d   = entry_w[0];
          out_last_d  = emit_last;
          ctrl.shift  = 1'b1;
          rank_d      = rank_q + spk_pkg::RankW'(1);
          if (emit_last) begin
            ctrl.clear = 1'b1;
            rank_d     = '0;
            state_d    = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  for (genvar i = 0; i < spk_pkg::Peaks; i++) begin : g_cell
    spk_pkg::entry_t carry_in;
    logic            bump_in;
    spk_pkg::entry_t up_in;
    if (i == 0) begin : g_head
      assign carry_in = ins;
      assign bump_in  = 1'b0;
    end else begin : g_body
      assign carry_in = carry_w[i-1];
      assign bump_in  = bump_w[i-1];
    end
    if (i == spk_pkg::Peaks - 1) begin : g_tail
      assign up_in = '0;
    end else begin : g_inner
      assign up_in = entry_w[i+1];
    end
    spk_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .carry_i (carry_in),
      .bump_i  (bump_in),
      .up_i    (up_in),
      .entry_o (entry_w[i]),
      .carry_o (carry_w[i]),
      .bump_o  (bump_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      rpt_q       <= spk_pkg::RptReset;
      drain_q     <= '0;
      rank_q      <= '0;
      have_prev_q <= 1'b0;
      taken_q     <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drain_q     <= drain_d;
      rank_q      <= rank_d;
      have_prev_q <= have_prev_d;
      taken_q     <= taken_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rpt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_rank_q <= out_rank_d;
    out_ent_q  <= out_ent_d;
    out_last_q <= out_last_d;
  end

  assign pk_o.valid          = out_valid_q;
  assign pk_o.peak_rank      = out_rank_q;
  assign pk_o.peak_mass      = out_ent_q.mass;
  assign pk_o.peak_abundance = out_ent_q.abundance;
  assign pk_o.last_peak      = out_last_q;

endmodule

[hw/rtl/spk_cell.sv]
`timescale 1ns / 1ps

module spk_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spk_pkg::cell_ctrl_t ctrl_i,
  input  spk_pkg::entry_t     carry_i,
  input  logic                bump_i,
  input  spk_pkg::entry_t     up_i,
  output spk_pkg::entry_t     entry_o,
  output spk_pkg::entry_t     carry_o,
  output logic                bump_o
);

  spk_pkg::entry_t entry_q, entry_d;
  spk_pkg::entry_t carry_q, carry_d;
  logic            bump_q, bump_d;

  // a passing peak takes this slot only when strictly larger, so ties stay behind
  // an entry pushed out of a slot above always moves down one, keeping tied entries in order
  always_comb begin
    entry_d = entry_q;
    carry_d = carry_i;
    bump_d  = bump_i;
    if (ctrl_i.clear) begin
      entry_d = '0;
      carry_d = '0;
      bump_d  = 1'b0;
    end else if (ctrl_i.shift) begin
      entry_d = up_i;
      carry_d = '0;
      bump_d  = 1'b0;
    end else if (bump_i || (carry_i.abundance > entry_q.abundance)) begin
      entry_d = carry_i;
      carry_d = entry_q;
      bump_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      carry_q <= '0;
      bump_q  <= 1'b0;
    end else begin
      entry_q <= entry_d;
      carry_q <= carry_d;
      bump_q  <= bump_d;
    end
  end

  assign entry_o = entry_q;
  assign carry_o = carry_q;
  assign bump_o  = bump_q;

endmodule

[hw/rtl/spk_checker.sv]
`timescale 1ns / 1ps

module spk_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      in_last_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [spk_pkg::RankW-1:0] out_rank_i,
  input  logic                      out_last_i
);

  // a stalled result keeps its place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rank_i) && $stable(out_last_i))
    else $error("stalled result dropped or changed");

  // the end of a spectrum stops sampling until the last result of the report has been registered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("sample taken right after spectrum end");

  // while a report run is still going no sample is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("sample taken during report run");

  // report results follow each other with no gap on the block side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i &&
      out_rank_i == $past(out_rank_i) + spk_pkg::RankW'(1))
    else $error("report run broken or rank skipped");

endmodule

bind spectrum_top_k_peak_finder_core spk_checker u_spk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .in_last_i   (smp_i.last_sample),
  .out_valid_i (pk_o.valid),
  .out_ready_i (pk_o.ready),
  .out_rank_i  (pk_o.peak_rank),
  .out_last_i  (pk_o.last_peak)
);
